FILE: src/eth_pkg.sv
package eth_pkg;

    // cordic datapath widths: q30 values plus headroom for cordic gain
    localparam int ROT_W = 34;
    localparam int VEC_W = 34;

    // cordic gain compensation, 0.6072529350 in q30
    localparam logic [29:0] CORDIC_K  = 30'd652032874;
    localparam logic [31:0] TURN_HALF = 32'h8000_0000;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] r;
        unique case (idx)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            24: r = 32'h00000029;
            25: r = 32'h00000014;
            26: r = 32'h0000000A;
            27: r = 32'h00000005;
            28: r = 32'h00000003;
            29: r = 32'h00000001;
            30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

FILE: src/eth_rot_cell.sv
module eth_rot_cell #(
    parameter int SHIFT = 0,
    parameter int PW    = 2
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [eth_pkg::ROT_W-1:0] x_in,
    input  logic signed [eth_pkg::ROT_W-1:0] y_in,
    input  logic signed [eth_pkg::ROT_W-1:0] z_in,
    input  logic        [PW-1:0]             p_in,
    output logic signed [eth_pkg::ROT_W-1:0] x_reg,
    output logic signed [eth_pkg::ROT_W-1:0] y_reg,
    output logic signed [eth_pkg::ROT_W-1:0] z_reg,
    output logic        [PW-1:0]             p_reg
);
    import eth_pkg::*;

    localparam logic signed [ROT_W-1:0] ATAN = ROT_W'(atan_turn(SHIFT));

    logic signed [ROT_W-1:0] dx, dy;
    logic signed [ROT_W-1:0] x_next, y_next, z_next;

    assign dx = y_in >>> SHIFT;
    assign dy = x_in >>> SHIFT;

    always_comb begin
        if (z_in >= 0) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            p_reg <= p_in;
        end
    end

endmodule

FILE: src/eth_vec_cell.sv
module eth_vec_cell #(
    parameter int SHIFT = 0,
    parameter int PW    = 33
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [eth_pkg::VEC_W-1:0] x_in,
    input  logic signed [eth_pkg::VEC_W-1:0] y_in,
    input  logic        [31:0]               z_in,
    input  logic        [PW-1:0]             p_in,
    output logic signed [eth_pkg::VEC_W-1:0] x_reg,
    output logic signed [eth_pkg::VEC_W-1:0] y_reg,
    output logic        [31:0]               z_reg,
    output logic        [PW-1:0]             p_reg
);
    import eth_pkg::*;

    localparam logic [31:0] ATAN = atan_turn(SHIFT);

    logic signed [VEC_W-1:0] dx, dy;
    logic signed [VEC_W-1:0] x_next, y_next;
    logic        [31:0]      z_next;

    assign dx = y_in >>> SHIFT;
    assign dy = x_in >>> SHIFT;

    always_comb begin
        if (y_in >= 0) begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end else begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            p_reg <= p_in;
        end
    end

endmodule

FILE: src/equatorial_to_horizontal.sv
// Equatorial to horizontal transform. Angles are binary fractions of a turn.
// Fully pipelined: one item per clock while the output is not stalled, built
// from three chains of CORDIC cells (sin/cos for hour angle, declination and
// latitude side by side, then two atan2 chains) plus the multiply stages.
// The whole pipeline advances when the output register is empty or taken,
// so s_tready follows m_tready while a result is held. observer_latitude is
// written via cfg_valid/cfg_data and is sampled with each input beat.
module equatorial_to_horizontal #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // right_ascension, declination, local_sidereal_angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // azimuth, altitude
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // observer_latitude
);
    import eth_pkg::*;

    localparam int N   = CORDIC_STAGES;
    localparam int SH  = 32 - ANGLE_BITS;
    localparam int LAT = 3 * N + 9;
    localparam logic [32:0] RND = (33'd1 << SH) >> 1;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic [15:0] lat_reg;

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_reg <= '0;
            vld_reg <= '0;
        end else begin
            if (cfg_valid) begin
                lat_reg <= cfg_data;
            end
            if (en) begin
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            end
        end
    end

    function automatic logic [31:0] to_turn(input logic [15:0] v, input logic sgn);
        logic [31:0] e;
        e = {{16{sgn & v[15]}}, v};
        return e << SH;
    endfunction

    // input stage: hour angle, declination, latitude as turns
    logic [31:0] ang_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg[0] <= to_turn(s_tdata[47:32], 1'b0) - to_turn(s_tdata[15:0], 1'b0);
            ang_reg[1] <= to_turn(s_tdata[31:16], 1'b1);
            ang_reg[2] <= to_turn(lat_reg, 1'b1);
        end
    end

    // sin/cos chains, one lane per angle
    logic signed [ROT_W-1:0] rx [3][N+1];
    logic signed [ROT_W-1:0] ry [3][N+1];
    logic signed [ROT_W-1:0] rz [3][N+1];
    logic        [1:0]       rq [3][N+1];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rx[l][0] = ROT_W'(CORDIC_K);
        assign ry[l][0] = '0;
        assign rz[l][0] = ROT_W'(ang_reg[l][29:0]);
        assign rq[l][0] = ang_reg[l][31:30];
        for (genvar j = 0; j < N; j++) begin : g_cell
            eth_rot_cell #(.SHIFT(j), .PW(2)) u_cell (
                .aclk (aclk), .en (en),
                .x_in (rx[l][j]), .y_in (ry[l][j]), .z_in (rz[l][j]), .p_in (rq[l][j]),
                .x_reg(rx[l][j+1]), .y_reg(ry[l][j+1]), .z_reg(rz[l][j+1]),
                .p_reg(rq[l][j+1])
            );
        end
    end

    // quadrant fold
    logic signed [31:0] cos_reg [3];
    logic signed [31:0] sin_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                unique case (rq[l][N])
                    2'd0: begin
                        cos_reg[l] <= 32'(rx[l][N]);
                        sin_reg[l] <= 32'(ry[l][N]);
                    end
                    2'd1: begin
                        cos_reg[l] <= 32'(-ry[l][N]);
                        sin_reg[l] <= 32'(rx[l][N]);
                    end
                    2'd2: begin
                        cos_reg[l] <= 32'(-rx[l][N]);
                        sin_reg[l] <= 32'(-ry[l][N]);
                    end
                    default: begin
                        cos_reg[l] <= 32'(ry[l][N]);
                        sin_reg[l] <= 32'(-rx[l][N]);
                    end
                endcase
            end
        end
    end

    // unit vector
    logic signed [63:0] pcx, pcy;
    logic signed [31:0] ux_reg, uy_reg, uz_reg, cl_reg, sl_reg;

    assign pcx = cos_reg[0] * cos_reg[1];
    assign pcy = sin_reg[0] * cos_reg[1];

    always_ff @(posedge aclk) begin
        if (en) begin
            ux_reg <= 32'(pcx >>> 30);
            uy_reg <= 32'(pcy >>> 30);
            uz_reg <= sin_reg[1];
            cl_reg <= cos_reg[2];
            sl_reg <= sin_reg[2];
        end
    end

    // rotation about latitude
    logic signed [63:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [31:0] ty_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg <= ux_reg * sl_reg;
            m2_reg <= uz_reg * cl_reg;
            m3_reg <= ux_reg * cl_reg;
            m4_reg <= uz_reg * sl_reg;
            ty_reg <= uy_reg;
        end
    end

    logic signed [64:0] dsum, asum;
    logic signed [31:0] tx_reg, tz_reg, ty2_reg;

    assign dsum = 65'(m1_reg) - 65'(m2_reg);
    assign asum = 65'(m3_reg) + 65'(m4_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            tx_reg  <= 32'(dsum >>> 30);
            tz_reg  <= 32'(asum >>> 30);
            ty2_reg <= ty_reg;
        end
    end

    // azimuth atan2, half-turn pre-rotation for negative x
    logic signed [VEC_W-1:0] ax [N+1];
    logic signed [VEC_W-1:0] ay [N+1];
    logic        [31:0]      az [N+1];
    logic        [32:0]      ap [N+1];
    logic signed [VEC_W-1:0] ax0_reg, ay0_reg;
    logic        [31:0]      az0_reg;
    logic        [32:0]      ap0_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ap0_reg <= {(tx_reg == 0) && (ty2_reg == 0), tz_reg};
            if (tx_reg < 0) begin
                ax0_reg <= -VEC_W'(tx_reg);
                ay0_reg <= -VEC_W'(ty2_reg);
                az0_reg <= TURN_HALF;
            end else begin
                ax0_reg <= VEC_W'(tx_reg);
                ay0_reg <= VEC_W'(ty2_reg);
                az0_reg <= '0;
            end
        end
    end

    assign ax[0] = ax0_reg;
    assign ay[0] = ay0_reg;
    assign az[0] = az0_reg;
    assign ap[0] = ap0_reg;

    for (genvar j = 0; j < N; j++) begin : g_vaz
        eth_vec_cell #(.SHIFT(j), .PW(33)) u_cell (
            .aclk (aclk), .en (en),
            .x_in (ax[j]), .y_in (ay[j]), .z_in (az[j]), .p_in (ap[j]),
            .x_reg(ax[j+1]), .y_reg(ay[j+1]), .z_reg(az[j+1]), .p_reg(ap[j+1])
        );
    end

    // horizontal length and final azimuth
    logic signed [VEC_W+31:0] mk_reg;
    logic        [31:0]       azt_reg;
    logic signed [31:0]       tz3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mk_reg  <= ax[N] * $signed({2'b00, CORDIC_K});
            azt_reg <= (ap[N][32] ? 32'd0 : az[N]) + TURN_HALF;
            tz3_reg <= ap[N][31:0];
        end
    end

    // altitude atan2, x is never negative here
    logic signed [31:0]      hyp;
    logic signed [VEC_W-1:0] bx [N+1];
    logic signed [VEC_W-1:0] by [N+1];
    logic        [31:0]      bz [N+1];
    logic        [32:0]      bp [N+1];
    logic signed [VEC_W-1:0] bx0_reg, by0_reg;
    logic        [32:0]      bp0_reg;

    assign hyp = 32'(mk_reg >>> 30);

    always_ff @(posedge aclk) begin
        if (en) begin
            bx0_reg <= VEC_W'(hyp);
            by0_reg <= VEC_W'(tz3_reg);
            bp0_reg <= {(hyp == 0) && (tz3_reg == 0), azt_reg};
        end
    end

    assign bx[0] = bx0_reg;
    assign by[0] = by0_reg;
    assign bz[0] = '0;
    assign bp[0] = bp0_reg;

    for (genvar j = 0; j < N; j++) begin : g_valt
        eth_vec_cell #(.SHIFT(j), .PW(33)) u_cell (
            .aclk (aclk), .en (en),
            .x_in (bx[j]), .y_in (by[j]), .z_in (bz[j]), .p_in (bp[j]),
            .x_reg(bx[j+1]), .y_reg(by[j+1]), .z_reg(bz[j+1]), .p_reg(bp[j+1])
        );
    end

    // round to output resolution
    logic [31:0]        alt_t, az_r;
    logic signed [32:0] alt_r;

    assign alt_t = bp[N][32] ? 32'd0 : bz[N];
    assign az_r  = (bp[N][31:0] + RND[31:0]) >> SH;
    assign alt_r = ($signed({alt_t[31], alt_t}) + $signed(RND)) >>> SH;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata <= {alt_r[15:0], az_r[15:0]};
        end
    end

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted beat lost at pipeline entry");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
    a_reaches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        en && vld_reg[LAT-2] |=> m_tvalid)
        else $error("beat lost before output register");

endmodule

FILE: verif/eth_checker.sv
`timescale 1ns / 1ps

module eth_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          n_fail,
    output int          n_pending
);

    // azimuth sits in the low half of the result beat
    typedef struct packed {
        logic [15:0] alt;
        logic [15:0] az;
    } horiz_t;

    localparam int STAGES = 16;
    localparam longint GAIN = 64'sd652032874;

    logic [15:0] latitude;
    horiz_t      horiz_q[$];

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] turn_of(logic [15:0] f);
        return {f, 16'h0000};
    endfunction

    function automatic void sincos(input logic [31:0] a, output longint c,
                                   output longint s);
        longint x, y, z, dx, dy;
        x = GAIN;
        y = 0;
        z = longint'(a[29:0]);
        for (int i = 0; i < STAGES; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(eth_pkg::atan_turn(i));
            end else begin
                x += dx; y -= dy; z += longint'(eth_pkg::atan_turn(i));
            end
        end
        case (a[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic logic [31:0] arctan2(input longint yi, input longint xi,
                                            output longint mag);
        longint x, y, dx, dy;
        logic [31:0] z;
        x = xi;
        y = yi;
        z = 32'h0;
        if (x == 0 && y == 0) begin
            mag = 0;
            return 32'h0;
        end
        if (x < 0) begin
            x = -x; y = -y; z = eth_pkg::TURN_HALF;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += eth_pkg::atan_turn(i);
            end else begin
                x -= dx; y += dy; z -= eth_pkg::atan_turn(i);
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic horiz_t to_horizon(logic [47:0] d, logic [15:0] lat);
        longint ch, sh, cd, sd, cl, sl, x, y, z, tx, tz, mag, hyp;
        logic [31:0] ha, az, alt;
        horiz_t r;
        ha = turn_of(d[47:32]) - turn_of(d[15:0]);
        sincos(ha, ch, sh);
        sincos(turn_of(d[31:16]), cd, sd);
        sincos(turn_of(lat), cl, sl);
        x = shr_floor(ch * cd, 30);
        y = shr_floor(sh * cd, 30);
        z = sd;
        tx = shr_floor(x * sl - z * cl, 30);
        tz = shr_floor(x * cl + z * sl, 30);
        az = arctan2(y, tx, mag) + eth_pkg::TURN_HALF;
        hyp = shr_floor(mag * GAIN, 30);
        alt = arctan2(tz, hyp, mag);
        // both round half up; signed shift of the wrapped sum gives the same bits
        az = az + 32'h8000;
        alt = alt + 32'h8000;
        r.az = az[31:16];
        r.alt = alt[31:16];
        return r;
    endfunction

    assign n_pending = horiz_q.size();

    always @(posedge aclk) begin
        horiz_t got, want;
        int     errs;
        if (!aresetn) begin
            latitude <= 16'h0;
            n_fail <= 0;
            horiz_q.delete();
        end else begin
            errs = 0;
            if (cfg_valid && cfg_ready)
                latitude <= cfg_data;
            if (s_tvalid && s_tready)
                horiz_q.push_back(to_horizon(s_tdata, latitude));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (horiz_q.size() == 0) begin
                    $error("unexpected result beat az=%0d alt=%0d", got.az, got.alt);
                    errs++;
                end else begin
                    want = horiz_q.pop_front();
                    if (got.az !== want.az) begin
                        $error("azimuth expected %0d actual %0d", want.az, got.az);
                        errs++;
                    end
                    if (got.alt !== want.alt) begin
                        $error("altitude expected %0d actual %0d",
                               $signed(want.alt), $signed(got.alt));
                        errs++;
                    end
                end
            end
            n_fail <= n_fail + errs;
        end
    end

endmodule

FILE: verif/tb_equatorial_to_horizontal.sv
`timescale 1ns / 1ps

module tb_equatorial_to_horizontal;

    localparam int LATENCY = 3 * 16 + 9;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    int          n_fail;
    int          n_pending;
    int          cycles = 0;
    logic        hold_off = 1'b0;

    always #6 aclk = ~aclk;

    equatorial_to_horizontal u_dut (.*);

    eth_checker u_chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_equatorial_to_horizontal: errors");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stalls, plus a long hold while the sender keeps offering
    initial begin
        int g;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            m_tready <= (g == 0);
            @(posedge aclk);
            if (g > 1) repeat (g - 1) @(posedge aclk);
            m_tready <= 1'b1;
        end
    end

    task automatic send_beat(logic [15:0] ra, logic [15:0] dec, logic [15:0] lst,
                             bit idle);
        int g;
        g = idle ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {lst, dec, ra};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic set_latitude(logic [15:0] lat);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= lat;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_dec();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom());
        if (r == 1) return ($urandom_range(0, 1) != 0) ? 16'h4000 : 16'hC000;
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    initial begin
        logic [15:0] lats[6];
        logic [15:0] dirs[5];
        lats = '{16'h4000, 16'hC000, 16'h0000, 16'h2000, 16'h7FFF, 16'h8000};
        dirs = '{16'h0000, 16'hFFFF, 16'h4000, 16'hC000, 16'h8000};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zenith/nadir, field extremes, out of range angles
        send_beat(16'h0000, 16'h4000, 16'h0000, 0);
        send_beat(16'h0000, 16'hC000, 16'h0000, 0);
        send_beat(16'h0000, 16'h0000, 16'h0000, 0);
        send_beat(16'hFFFF, 16'h7FFF, 16'h0000, 0);
        send_beat(16'h0000, 16'h8000, 16'hFFFF, 0);
        send_beat(16'h8000, 16'hFFFF, 16'h4000, 0);
        set_latitude(16'h4000);
        send_beat(16'h1234, 16'h4000, 16'h1234, 0);
        send_beat(16'h0000, 16'h0000, 16'h4000, 0);
        set_latitude(16'hC000);
        send_beat(16'h0000, 16'hC000, 16'h0000, 0);
        send_beat(16'hFFFF, 16'h1000, 16'h7000, 0);
        foreach (dirs[i]) send_beat(dirs[i], dirs[(i + 2) % 5], dirs[4 - i], 0);

        foreach (lats[p]) begin
            set_latitude(p == 5 ? 16'($urandom()) : lats[p]);
            if (p == 2) hold_off = 1'b1;
            for (int k = 0; k < 272; k++)
                send_beat(16'($urandom()), rand_dec(), 16'($urandom()),
                          (p != 2) && ($urandom_range(0, 2) != 0));
        end
        s_tvalid <= 1'b0;

        while (n_pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (n_fail == 0)
            $display("tb_equatorial_to_horizontal: clean");
        else
            $display("tb_equatorial_to_horizontal: errors");
        $finish;
    end

endmodule

FILE: sim.f
src/eth_pkg.sv
src/eth_rot_cell.sv
src/eth_vec_cell.sv
src/equatorial_to_horizontal.sv
verif/eth_checker.sv
verif/tb_equatorial_to_horizontal.sv
